@@ hdl/bdclp_pkg.sv @@
package bdclp_pkg;

  localparam int CLICK_BITS_DEFAULT = 8;
  localparam int TIMER_BITS_DEFAULT = 17;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [1:0]                status_t;

  localparam cfg_index_t REG_DEBOUNCE_TICKS   = 2'd0;
  localparam cfg_index_t REG_LONG_PRESS_TICKS = 2'd1;
  localparam cfg_index_t REG_RELEASED_LEVEL   = 2'd2;

  localparam status_t STATUS_OFF  = 2'd0;
  localparam status_t STATUS_ON   = 2'd1;
  localparam status_t STATUS_LONG = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_TICKS_RESET   = 16'd50;
  localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_TICKS_RESET = 16'd1000;

endpackage

@@ hdl/button_debounce_click_long_press.sv @@
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_stall | pin_level, take_click
// output   | out_valid/out_stall | button_status, click_taken, clicks_pending
// config   | cfg_write           | cfg_index, cfg_data
//
// One tick per transaction; the state update and the result
// are computed in the accept cycle and land in the output register, or in
// the skid entry while the output is stalled.
// A two-entry output stage (register plus skid) lets a new transaction in
// while a result waits; in_stall rises only when both entries are full.
// rst is synchronous: registers take their reset values, output is empty.
module button_debounce_click_long_press #(
  parameter int CLICK_BITS = bdclp_pkg::CLICK_BITS_DEFAULT,
  parameter int TIMER_BITS = bdclp_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pin_level,
  input  logic                           take_click,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bdclp_pkg::status_t             button_status,
  output logic                           click_taken,
  output logic [CLICK_BITS-1:0]          clicks_pending,
  input  logic                           cfg_write,
  input  bdclp_pkg::cfg_index_t          cfg_index,
  input  logic [bdclp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import bdclp_pkg::*;

  localparam int CMP_BITS = (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [CLICK_BITS-1:0] CLICK_MAX = {CLICK_BITS{1'b1}};

  logic [CFG_DATA_BITS-1:0] debounce_ticks;
  logic [CFG_DATA_BITS-1:0] long_press_ticks;
  logic                     released_level;

  logic                  last_level;
  logic [TIMER_BITS-1:0] settle_count;
  logic [TIMER_BITS-1:0] hold_count;
  logic                  release_armed;
  status_t               stable_status;
  logic [CLICK_BITS-1:0] click_store;

  logic                  last_level_next;
  logic [TIMER_BITS-1:0] settle_count_next;
  logic [TIMER_BITS-1:0] hold_count_next;
  logic                  release_armed_next;
  status_t               stable_status_next;
  logic [CLICK_BITS-1:0] click_store_next;
  logic                  taken_next;

  logic                  skid_valid;
  status_t               skid_status;
  logic                  skid_taken;
  logic [CLICK_BITS-1:0] skid_clicks;

  logic accept;
  logic active;
  logic settle_inc_max;
  logic hold_inc_max;
  logic [TIMER_BITS-1:0] settle_inc;
  logic [TIMER_BITS-1:0] hold_inc;
  logic [CLICK_BITS-1:0] click_added;
  logic out_load;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign active   = (pin_level != released_level);

  assign settle_inc_max = (settle_count == TIMER_MAX);
  assign hold_inc_max   = (hold_count == TIMER_MAX);
  assign settle_inc     = settle_inc_max ? TIMER_MAX : settle_count + 1'b1;
  assign hold_inc       = hold_inc_max ? TIMER_MAX : hold_count + 1'b1;

  always_comb begin
    last_level_next    = last_level;
    settle_count_next  = settle_count;
    hold_count_next    = hold_count;
    release_armed_next = release_armed;
    stable_status_next = stable_status;
    click_added        = click_store;
    if (pin_level != last_level) begin
      last_level_next    = pin_level;
      settle_count_next  = '0;
      hold_count_next    = active ? '0 : hold_inc;
      release_armed_next = !active;
    end else begin
      settle_count_next = settle_inc;
      hold_count_next   = hold_inc;
      if (CMP_BITS'(settle_inc) > CMP_BITS'(debounce_ticks)) begin
        if (active) begin
          stable_status_next = (CMP_BITS'(hold_inc) > CMP_BITS'(long_press_ticks)) ?
                               STATUS_LONG : STATUS_ON;
        end else begin
          if (release_armed) begin
            release_armed_next = 1'b0;
            if (stable_status != STATUS_LONG && click_store != CLICK_MAX) begin
              click_added = click_store + 1'b1;
            end
          end
          stable_status_next = STATUS_OFF;
        end
      end
    end
    taken_next       = take_click && (click_added != '0);
    click_store_next = taken_next ? click_added - 1'b1 : click_added;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_TICKS_RESET;
      long_press_ticks <= LONG_PRESS_TICKS_RESET;
      released_level   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        REG_RELEASED_LEVEL:   released_level   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b1;
      settle_count  <= '0;
      hold_count    <= '0;
      release_armed <= 1'b0;
      stable_status <= STATUS_OFF;
      click_store   <= '0;
    end else if (accept) begin
      last_level    <= last_level_next;
      settle_count  <= settle_count_next;
      hold_count    <= hold_count_next;
      release_armed <= release_armed_next;
      stable_status <= stable_status_next;
      click_store   <= click_store_next;
    end
  end

  // output register refills from skid first, else straight from this tick
  assign out_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        button_status  <= skid_status;
        click_taken    <= skid_taken;
        clicks_pending <= skid_clicks;
      end else if (accept) begin
        button_status  <= stable_status_next;
        click_taken    <= taken_next;
        clicks_pending <= click_store_next;
      end
    end else if (accept) begin
      skid_status <= stable_status_next;
      skid_taken  <= taken_next;
      skid_clicks <= click_store_next;
    end
  end

endmodule

@@ hdl/bdclp_check.sv @@
module bdclp_check #(
  parameter int CLICK_BITS = bdclp_pkg::CLICK_BITS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input bdclp_pkg::status_t    button_status,
  input logic                  click_taken,
  input logic [CLICK_BITS-1:0] clicks_pending
);
  import bdclp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(button_status) &&
                               $stable(click_taken) && $stable(clicks_pending))
    else $error("output transaction changed while stalled");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_taken_below_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && click_taken |-> clicks_pending != {CLICK_BITS{1'b1}})
    else $error("click taken yet count at saturation");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind button_debounce_click_long_press bdclp_check #(.CLICK_BITS(CLICK_BITS)) u_bdclp_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .button_status  (button_status),
  .click_taken    (click_taken),
  .clicks_pending (clicks_pending)
);
